>>> hdl/bbpe_pkg.sv
// shared types and constants for the bicubic bezier patch evaluator
// no dependencies
package bbpe_pkg;

  localparam int PARAM_W    = 17;
  localparam int BASIS_FRAC = 24;
  localparam int BASIS_W    = 27;   // signed width carrying either basis
  localparam int PLAIN_W    = 25;   // unsigned plain basis, q.24
  localparam int POINTS     = 16;
  localparam int IDX_W      = 4;
  localparam int OUT_W      = 32;
  localparam logic [PARAM_W-1:0] PARAM_ONE = 17'h10000;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  // control point write toward the per-axis stores
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
  } wr_t;

endpackage

>>> hdl/bbpe_basis.sv
// two-stage cubic bernstein basis and derivative basis for one parameter
// depends on bbpe_pkg
module bbpe_basis (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [bbpe_pkg::PARAM_W-1:0]            t_in,
  output logic [bbpe_pkg::PLAIN_W-1:0]            plain_r [4],
  output logic signed [bbpe_pkg::BASIS_W-1:0]     slope_r [4]
);

  logic [bbpe_pkg::PARAM_W-1:0] t_c, s_c, t_r, s_r;
  logic [33:0] ss_r, ts_r, tt_r;
  logic [51:0] m0, m1, m2, m3, c1, c2, half_p;
  logic signed [36:0] ssx, tsx, ttx, ss3, ts6, tt3, e0, e1, e2, e3;
  logic signed [36:0] r0, r1, r2, r3;

  // stage 1: clamp, complement and squares
  assign t_c = (t_in > bbpe_pkg::PARAM_ONE) ? bbpe_pkg::PARAM_ONE : t_in;
  assign s_c = bbpe_pkg::PARAM_ONE - t_c;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_c;
      s_r  <= s_c;
      ss_r <= 34'(s_c) * 34'(s_c);
      ts_r <= 34'(t_c) * 34'(s_c);
      tt_r <= 34'(t_c) * 34'(t_c);
    end
  end

  // stage 2: cubes and rounding
  assign half_p = 52'd1 << (bbpe_pkg::BASIS_FRAC - 1);
  assign m0 = 52'(ss_r) * 52'(s_r);
  assign m1 = 52'(ss_r) * 52'(t_r);
  assign m2 = 52'(tt_r) * 52'(s_r);
  assign m3 = 52'(tt_r) * 52'(t_r);
  assign c1 = (m1 << 1) + m1;
  assign c2 = (m2 << 1) + m2;

  assign ssx = $signed(37'(ss_r));
  assign tsx = $signed(37'(ts_r));
  assign ttx = $signed(37'(tt_r));
  assign ss3 = (ssx <<< 1) + ssx;
  assign tt3 = (ttx <<< 1) + ttx;
  assign ts6 = (tsx <<< 2) + (tsx <<< 1);
  assign e0  = -ss3;
  assign e1  = ss3 - ts6;
  assign e2  = ts6 - tt3;
  assign e3  = tt3;
  assign r0  = (e0 + 37'sd128) >>> 8;
  assign r1  = (e1 + 37'sd128) >>> 8;
  assign r2  = (e2 + 37'sd128) >>> 8;
  assign r3  = (e3 + 37'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      plain_r[0] <= 25'((m0 + half_p) >> bbpe_pkg::BASIS_FRAC);
      plain_r[1] <= 25'((c1 + half_p) >> bbpe_pkg::BASIS_FRAC);
      plain_r[2] <= 25'((c2 + half_p) >> bbpe_pkg::BASIS_FRAC);
      plain_r[3] <= 25'((m3 + half_p) >> bbpe_pkg::BASIS_FRAC);
      slope_r[0] <= $signed(r0[bbpe_pkg::BASIS_W-1:0]);
      slope_r[1] <= $signed(r1[bbpe_pkg::BASIS_W-1:0]);
      slope_r[2] <= $signed(r2[bbpe_pkg::BASIS_W-1:0]);
      slope_r[3] <= $signed(r3[bbpe_pkg::BASIS_W-1:0]);
    end
  end

endmodule

>>> hdl/bbpe_axis.sv
// control point store and four-stage row/column reduction for one axis
// depends on bbpe_pkg
module bbpe_axis #(
  parameter int CW = 32
) (
  input  logic                                clk,
  input  logic                                en,
  input  bbpe_pkg::wr_t                       wr,
  input  logic signed [CW-1:0]                wr_coord,
  input  logic signed [bbpe_pkg::BASIS_W-1:0] bu [4],
  input  logic signed [bbpe_pkg::BASIS_W-1:0] su [4],
  input  logic signed [bbpe_pkg::BASIS_W-1:0] bv [4],
  input  logic signed [bbpe_pkg::BASIS_W-1:0] sv [4],
  output logic signed [bbpe_pkg::OUT_W-1:0]   pos_r,
  output logic signed [bbpe_pkg::OUT_W-1:0]   du_r,
  output logic signed [bbpe_pkg::OUT_W-1:0]   dv_r
);

  localparam int P1W = bbpe_pkg::BASIS_W + CW;
  localparam int S1W = P1W + 2;
  localparam int RW  = CW + 4;
  localparam int P2W = bbpe_pkg::BASIS_W + RW;
  localparam int S2W = P2W + 2;
  localparam logic signed [S1W-1:0] HALF1 = S1W'(1) <<< (bbpe_pkg::BASIS_FRAC - 1);
  localparam logic signed [S2W-1:0] HALF2 = S2W'(1) <<< (bbpe_pkg::BASIS_FRAC - 1);
  localparam logic signed [S2W-1:0] SAT_HI = (S2W'(1) <<< (CW - 1)) - S2W'(1);
  localparam logic signed [S2W-1:0] SAT_LO = ~SAT_HI;

  logic signed [CW-1:0]  store_r [bbpe_pkg::POINTS];
  logic signed [P1W-1:0] pb_r [4][4];
  logic signed [P1W-1:0] ps_r [4][4];
  logic signed [RW-1:0]  row_r [4];
  logic signed [RW-1:0]  rdu_r [4];
  logic signed [bbpe_pkg::BASIS_W-1:0] bv3_r [4], bv4_r [4], sv3_r [4], sv4_r [4];
  logic signed [P2W-1:0] qp_r [4], qu_r [4], qv_r [4];
  logic signed [S1W-1:0] sb [4], sd [4], rb [4], rd [4];
  logic signed [S2W-1:0] sp, su2, sv2, rp, ru, rv;
  logic signed [CW-1:0]  cp, cu, cv;

  // store is written by a load in the same stage that evaluates read it
  always_ff @(posedge clk) begin
    if (wr.we) begin
      store_r[wr.idx] <= wr_coord;
    end
  end

  // stage 3: row products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        bv3_r[i] <= bv[i];
        sv3_r[i] <= sv[i];
        for (int j = 0; j < 4; j++) begin
          pb_r[i][j] <= P1W'(bu[j]) * P1W'(store_r[i*4+j]);
          ps_r[i][j] <= P1W'(su[j]) * P1W'(store_r[i*4+j]);
        end
      end
    end
  end

  // stage 4: row sums, rounded to q16.16
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sb[i] = S1W'(pb_r[i][0]) + S1W'(pb_r[i][1]) + S1W'(pb_r[i][2]) + S1W'(pb_r[i][3]);
      sd[i] = S1W'(ps_r[i][0]) + S1W'(ps_r[i][1]) + S1W'(ps_r[i][2]) + S1W'(ps_r[i][3]);
      rb[i] = (sb[i] + HALF1) >>> bbpe_pkg::BASIS_FRAC;
      rd[i] = (sd[i] + HALF1) >>> bbpe_pkg::BASIS_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        row_r[i] <= $signed(rb[i][RW-1:0]);
        rdu_r[i] <= $signed(rd[i][RW-1:0]);
        bv4_r[i] <= bv3_r[i];
        sv4_r[i] <= sv3_r[i];
      end
    end
  end

  // stage 5: column products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        qp_r[i] <= P2W'(bv4_r[i]) * P2W'(row_r[i]);
        qu_r[i] <= P2W'(bv4_r[i]) * P2W'(rdu_r[i]);
        qv_r[i] <= P2W'(sv4_r[i]) * P2W'(row_r[i]);
      end
    end
  end

  // stage 6: column sums, rounding, saturation
  assign sp  = S2W'(qp_r[0]) + S2W'(qp_r[1]) + S2W'(qp_r[2]) + S2W'(qp_r[3]);
  assign su2 = S2W'(qu_r[0]) + S2W'(qu_r[1]) + S2W'(qu_r[2]) + S2W'(qu_r[3]);
  assign sv2 = S2W'(qv_r[0]) + S2W'(qv_r[1]) + S2W'(qv_r[2]) + S2W'(qv_r[3]);
  assign rp  = (sp + HALF2) >>> bbpe_pkg::BASIS_FRAC;
  assign ru  = (su2 + HALF2) >>> bbpe_pkg::BASIS_FRAC;
  assign rv  = (sv2 + HALF2) >>> bbpe_pkg::BASIS_FRAC;

  always_comb begin
    cp = (rp > SAT_HI) ? SAT_HI[CW-1:0] : (rp < SAT_LO) ? SAT_LO[CW-1:0] : rp[CW-1:0];
    cu = (ru > SAT_HI) ? SAT_HI[CW-1:0] : (ru < SAT_LO) ? SAT_LO[CW-1:0] : ru[CW-1:0];
    cv = (rv > SAT_HI) ? SAT_HI[CW-1:0] : (rv < SAT_LO) ? SAT_LO[CW-1:0] : rv[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= bbpe_pkg::OUT_W'(cp);
      du_r  <= bbpe_pkg::OUT_W'(cu);
      dv_r  <= bbpe_pkg::OUT_W'(cv);
    end
  end

endmodule

>>> hdl/bicubic_bezier_patch_evaluator_unit.sv
// top level of the bicubic bezier patch evaluator
// depends on bbpe_pkg, bbpe_basis and bbpe_axis
//
// usage:
//   input channel (in_valid/in_ready): a beat with in_cmd load writes one
//   control point (in_point_index = row*4 + column, in_coord_x/y/z in q16.16);
//   a beat with in_cmd eval carries in_param_u/in_param_v (q1.16, values
//   above 1.0 act as 1.0) and yields one output beat.
//   output channel (out_valid/out_ready): surface point plus d/du and d/dv,
//   each saturated q16.16. load beats produce no output beat.
//   all 16 points are to be loaded before the first eval beat.
//   throughput one beat per cycle while no output beat waits, set by a
//   six-stage pipeline: clamp and squares, basis cubes, row products, row
//   sums, column products, column sums with saturation.
//   loads land in the store at the row product stage, so evals before and
//   after a load see the points in beat order.
//   stall: the whole pipeline holds while an output beat waits, and
//   in_ready drops with it; bubbles travel as invalid stages.
//   reset (rst_n low, synchronous) clears all stage valids; the point store
//   is not cleared.
module bicubic_bezier_patch_evaluator_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [bbpe_pkg::IDX_W-1:0]          in_point_index,
  input  logic signed [31:0]                  in_coord_x,
  input  logic signed [31:0]                  in_coord_y,
  input  logic signed [31:0]                  in_coord_z,
  input  logic [bbpe_pkg::PARAM_W-1:0]        in_param_u,
  input  logic [bbpe_pkg::PARAM_W-1:0]        in_param_v,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_pos_x,
  output logic signed [31:0]                  out_pos_y,
  output logic signed [31:0]                  out_pos_z,
  output logic signed [31:0]                  out_du_x,
  output logic signed [31:0]                  out_du_y,
  output logic signed [31:0]                  out_du_z,
  output logic signed [31:0]                  out_dv_x,
  output logic signed [31:0]                  out_dv_y,
  output logic signed [31:0]                  out_dv_z
);

  // stored coordinate width, capped at the 32-bit port
  localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  bbpe_pkg::cmd_t cmd1_r, cmd2_r;
  logic [bbpe_pkg::IDX_W-1:0] idx1_r, idx2_r;
  logic signed [CW-1:0] cx1_r, cy1_r, cz1_r, cx2_r, cy2_r, cz2_r;
  bbpe_pkg::wr_t wr;

  logic [bbpe_pkg::PLAIN_W-1:0] pu [4], pv [4];
  logic signed [bbpe_pkg::BASIS_W-1:0] bu [4], su [4], bv [4], sv [4];

  // global advance: everything moves unless a finished beat is blocked
  assign en        = !v6_r || out_ready;
  assign in_ready  = en;
  assign out_valid = v6_r;

  // control and load payload through the first two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      // only evals continue past the store stage
      v3_r <= v2_r && (cmd2_r == bbpe_pkg::CMD_EVAL);
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= bbpe_pkg::cmd_t'(in_cmd);
      idx1_r <= in_point_index;
      cx1_r  <= $signed(in_coord_x[CW-1:0]);
      cy1_r  <= $signed(in_coord_y[CW-1:0]);
      cz1_r  <= $signed(in_coord_z[CW-1:0]);
      cmd2_r <= cmd1_r;
      idx2_r <= idx1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      cz2_r  <= cz1_r;
    end
  end

  // a load in stage two writes the store as it advances
  assign wr.we  = en && v2_r && (cmd2_r == bbpe_pkg::CMD_LOAD);
  assign wr.idx = idx2_r;

  bbpe_basis u_basis_u (
    .clk     (clk),
    .en      (en),
    .t_in    (in_param_u),
    .plain_r (pu),
    .slope_r (su)
  );

  bbpe_basis u_basis_v (
    .clk     (clk),
    .en      (en),
    .t_in    (in_param_v),
    .plain_r (pv),
    .slope_r (sv)
  );

  // plain basis widened to the shared signed form
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bu[i] = $signed({2'b00, pu[i]});
      bv[i] = $signed({2'b00, pv[i]});
    end
  end

  bbpe_axis #(.CW(CW)) u_axis_x (
    .clk      (clk),
    .en       (en),
    .wr       (wr),
    .wr_coord (cx2_r),
    .bu       (bu),
    .su       (su),
    .bv       (bv),
    .sv       (sv),
    .pos_r    (out_pos_x),
    .du_r     (out_du_x),
    .dv_r     (out_dv_x)
  );

  bbpe_axis #(.CW(CW)) u_axis_y (
    .clk      (clk),
    .en       (en),
    .wr       (wr),
    .wr_coord (cy2_r),
    .bu       (bu),
    .su       (su),
    .bv       (bv),
    .sv       (sv),
    .pos_r    (out_pos_y),
    .du_r     (out_du_y),
    .dv_r     (out_dv_y)
  );

  bbpe_axis #(.CW(CW)) u_axis_z (
    .clk      (clk),
    .en       (en),
    .wr       (wr),
    .wr_coord (cz2_r),
    .bu       (bu),
    .su       (su),
    .bv       (bv),
    .sv       (sv),
    .pos_r    (out_pos_z),
    .du_r     (out_du_z),
    .dv_r     (out_dv_z)
  );

endmodule

>>> dv/bicubic_bezier_patch_evaluator_unit_test.sv
// self-checking testbench for bicubic_bezier_patch_evaluator_unit
// depends on bbpe_pkg and the evaluator rtl; predicts each eval beat
// in fixed point and checks every output beat in order
module bicubic_bezier_patch_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_DEPTH  = 6;
  localparam int PW          = bbpe_pkg::PARAM_W;
  localparam int IW          = bbpe_pkg::IDX_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = bbpe_pkg::CMD_LOAD;
  logic [IW-1:0] in_point_index = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [PW-1:0] in_param_u = '0, in_param_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_du_x, out_du_y, out_du_z;
  logic signed [31:0] out_dv_x, out_dv_y, out_dv_z;

  bicubic_bezier_patch_evaluator_unit dut (.*);

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // nine surface fields in output order: pos xyz, du xyz, dv xyz
  typedef logic [8:0][31:0] surface_t;
  string field_name [9] = '{"pos_x", "pos_y", "pos_z", "du_x", "du_y", "du_z",
                            "dv_x", "dv_y", "dv_z"};

  surface_t pending_surfaces[$];
  longint   patch_x [16], patch_y [16], patch_z [16];
  int       error_count = 0;
  int       cycle_count = 0;
  int       loads_sent = 0, evals_sent = 0, surfaces_seen = 0;
  bit       no_idle = 1'b0;     // quiet stretch: neither side idles
  int       stall_ask = 0;      // bumped by tests to request a long sink stall
  int       stall_seen = 0;
  int       stall_left = 0;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  // round half up then drop n fraction bits (>>> on signed is a floor)
  function automatic longint round_drop(longint a, int n);
    longint b;
    b = a + (longint'(1) <<< (n - 1));
    return b >>> n;
  endfunction

  function automatic longint clamp_unit(logic [PW-1:0] p);
    return (p > bbpe_pkg::PARAM_ONE) ? longint'(bbpe_pkg::PARAM_ONE) : longint'(p);
  endfunction

  // bernstein weights, q.24
  function automatic void bernstein(longint t, output longint w [4]);
    longint s;
    s = 65536 - t;
    w[0] = round_drop(s * s * s, 48 - bbpe_pkg::BASIS_FRAC);
    w[1] = round_drop(3 * t * s * s, 48 - bbpe_pkg::BASIS_FRAC);
    w[2] = round_drop(3 * t * t * s, 48 - bbpe_pkg::BASIS_FRAC);
    w[3] = round_drop(t * t * t, 48 - bbpe_pkg::BASIS_FRAC);
  endfunction

  // derivative weights, q.24
  function automatic void bernstein_slope(longint t, output longint w [4]);
    longint s;
    s = 65536 - t;
    w[0] = round_drop(-3 * s * s, 32 - bbpe_pkg::BASIS_FRAC);
    w[1] = round_drop(3 * s * s - 6 * t * s, 32 - bbpe_pkg::BASIS_FRAC);
    w[2] = round_drop(6 * t * s - 3 * t * t, 32 - bbpe_pkg::BASIS_FRAC);
    w[3] = round_drop(3 * t * t, 32 - bbpe_pkg::BASIS_FRAC);
  endfunction

  function automatic longint blend4(longint w [4], longint p0, longint p1,
                                    longint p2, longint p3);
    return round_drop(w[0] * p0 + w[1] * p1 + w[2] * p2 + w[3] * p3,
                      bbpe_pkg::BASIS_FRAC);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic surface_t predict_surface(logic [PW-1:0] pu,
                                               logic [PW-1:0] pv);
    longint bu [4], su [4], bv [4], sv [4];
    longint pts [16];
    longint row [4], row_du [4];
    surface_t r;
    bernstein(clamp_unit(pu), bu);
    bernstein_slope(clamp_unit(pu), su);
    bernstein(clamp_unit(pv), bv);
    bernstein_slope(clamp_unit(pv), sv);
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 16; k++)
        pts[k] = (a == 0) ? patch_x[k] : (a == 1) ? patch_y[k] : patch_z[k];
      // rows first along u, then the column along v
      for (int i = 0; i < 4; i++) begin
        row[i]    = blend4(bu, pts[4*i], pts[4*i+1], pts[4*i+2], pts[4*i+3]);
        row_du[i] = blend4(su, pts[4*i], pts[4*i+1], pts[4*i+2], pts[4*i+3]);
      end
      r[a]     = sat32(blend4(bv, row[0], row[1], row[2], row[3]));
      r[3 + a] = sat32(blend4(bv, row_du[0], row_du[1], row_du[2], row_du[3]));
      r[6 + a] = sat32(blend4(sv, row[0], row[1], row[2], row[3]));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one beat, random gaps before it, prediction on acceptance
  // ---------------------------------------------------------------------------
  task automatic send_beat(bbpe_pkg::cmd_t cmd, logic [IW-1:0] slot,
                           logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z,
                           logic [PW-1:0] u, logic [PW-1:0] v);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_cmd         <= cmd;
    in_point_index <= slot;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    in_param_u     <= u;
    in_param_v     <= v;
    // handshake sampled at the rising edge, before the dut updates
    do @(posedge clk); while (!in_ready);
    if (cmd == bbpe_pkg::CMD_LOAD) begin
      patch_x[slot] = longint'(x);
      patch_y[slot] = longint'(y);
      patch_z[slot] = longint'(z);
      loads_sent++;
    end else begin
      pending_surfaces = {pending_surfaces, predict_surface(u, v)};
      evals_sent++;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait until every predicted surface has come out
  task automatic drain;
    while (pending_surfaces.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(1 << 24)) - (1 << 23);
    endcase
  endfunction

  function automatic logic [PW-1:0] pick_param();
    case ($urandom_range(9))
      0: return '0;
      1: return bbpe_pkg::PARAM_ONE;
      2: return PW'($urandom_range(131071));     // includes values above one
      default: return PW'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_load;
    send_beat(bbpe_pkg::CMD_LOAD, IW'($urandom_range(15)), pick_coord(), pick_coord(),
              pick_coord(), PW'($urandom_range(131071)), PW'($urandom_range(131071)));
  endtask

  task automatic random_eval;
    send_beat(bbpe_pkg::CMD_EVAL, IW'($urandom_range(15)), $urandom, $urandom, $urandom,
              pick_param(), pick_param());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full patch load with extremes, then the corner and above-one parameters
  task automatic test_directed;
    for (int i = 0; i < 16; i++)
      send_beat(bbpe_pkg::CMD_LOAD, i[3:0],
                (i % 3 == 0) ? 32'sh7fffffff : (i % 3 == 1) ? 32'sh80000000 : 32'sh00010000,
                $signed(i << 16), -$signed(i << 14), '1, '1);
    send_beat(bbpe_pkg::CMD_EVAL, '0, '0, '0, '0, '0, '0);
    send_beat(bbpe_pkg::CMD_EVAL, '1, '1, '1, '1, bbpe_pkg::PARAM_ONE, bbpe_pkg::PARAM_ONE);
    send_beat(bbpe_pkg::CMD_EVAL, '0, '0, '0, '0, 17'h1ffff, 17'h10001);
    send_beat(bbpe_pkg::CMD_EVAL, '0, '0, '0, '0, 17'h08000, 17'h00001);
    send_beat(bbpe_pkg::CMD_EVAL, '0, '0, '0, '0, 17'h0ffff, 17'h08000);
    // a load between evals must be seen in beat order
    send_beat(bbpe_pkg::CMD_LOAD, 4'd5, 32'sh7fffffff, 32'sh80000000, '0, '0, '0);
    send_beat(bbpe_pkg::CMD_EVAL, '0, '0, '0, '0, 17'h08000, 17'h08000);
  endtask

  // mostly evals against a loaded patch, loads sprinkled in
  task automatic test_random_stream(int count, bit quiet);
    no_idle = quiet;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) random_load();
      else random_eval();
    end
    no_idle = 1'b0;
  endtask

  // sink holds off a long time while evals keep coming, so in_ready drops
  task automatic test_backpressure;
    stall_ask++;
    for (int n = 0; n < 40; n++) random_eval();
  endtask

  // sender pauses until the pipeline is empty, then bursts again
  task automatic test_drain_and_burst;
    drain();
    for (int n = 0; n < 30; n++) random_eval();
  endtask

  // ---------------------------------------------------------------------------
  // sink: random stalls plus the requested long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_seen != stall_ask) begin
      stall_seen <= stall_ask;
      stall_left <= 200;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    surface_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_dv_z, out_dv_y, out_dv_x, out_du_z, out_du_y, out_du_x,
              out_pos_z, out_pos_y, out_pos_x};
      if (pending_surfaces.size() == 0) begin
        report_mismatch("output beat with nothing expected");
      end else begin
        want = pending_surfaces.pop_front();
        for (int f = 0; f < 9; f++)
          if (seen[f] !== want[f])
            report_mismatch($sformatf("%s got %h want %h", field_name[f], seen[f],
                                      want[f]));
      end
      surfaces_seen++;
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bicubic_bezier_patch_evaluator_unit_test: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      patch_x[i] = 0;
      patch_y[i] = 0;
      patch_z[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_stream(250, 1'b0);
    test_random_stream(120, 1'b1);
    test_backpressure();
    test_drain_and_burst();
    test_random_stream(300, 1'b0);

    drain();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    $display("covered %0d point loads and %0d evals (%0d surfaces checked),",
             loads_sent, evals_sent, surfaces_seen);
    $display("  with corner and above-one parameters, saturation, stalls and a drain");
    if (error_count == 0 && pending_surfaces.size() == 0)
      $display("bicubic_bezier_patch_evaluator_unit_test: clean");
    else
      $display("bicubic_bezier_patch_evaluator_unit_test: errors");
    $finish;
  end

endmodule

>>> bicubic_bezier_patch_evaluator_unit.f
hdl/bbpe_pkg.sv
hdl/bbpe_basis.sv
hdl/bbpe_axis.sv
hdl/bicubic_bezier_patch_evaluator_unit.sv
dv/bicubic_bezier_patch_evaluator_unit_test.sv
